[hdl/nta_pkg.sv]
// Package for the number-to-ASCII formatter: format codes, FSM states,
// character constants and the control struct of the binary-to-BCD shifter.
// No dependencies.
package nta_pkg;

  // Format selector codes
  typedef enum logic [1:0] {
    ACT_UDEC = 2'd0,
    ACT_SDEC = 2'd1,
    ACT_HEX  = 2'd2,
    ACT_BIN  = 2'd3
  } nta_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD,
    ST_SKIP,
    ST_EMIT
  } nta_state_e;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DEC_DIGITS = 10;          // digits of 2^32-1
  localparam int unsigned DIG_W      = 4 * DEC_DIGITS;
  localparam int unsigned HEX_DIGITS = VALUE_W / 4;
  localparam int unsigned CONV_STEPS = VALUE_W;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_HEX_OFF = 8'd55;
  localparam logic [7:0] ASCII_MINUS   = 8'd45;
  localparam logic [3:0] DEC_BASE      = 4'd10;

  // Control of the double-dabble shifter
  typedef struct packed {
    logic clr;      // clear the BCD register
    logic shift;    // adjust and shift in one bit
    logic bit_in;   // next value bit, MSB first
  } nta_dab_ctl_t;

endpackage

[hdl/nta_dabble.sv]
// Bit-serial binary-to-BCD converter (shift and add-3), one bit per cycle while shift is set.
// Depends on nta_pkg.
module nta_dabble
  import nta_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  nta_dab_ctl_t ctl_i,
  output logic [DIG_W-1:0] bcd_o
);

  logic [DIG_W-1:0] bcd_q, bcd_d, adj;

  // add 3 to every digit of 5 or more, then shift the new bit in
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                               : bcd_q[4*i +: 4];
    end
    bcd_d = bcd_q;
    if (ctl_i.clr) begin
      bcd_d = '0;
    end else if (ctl_i.shift) begin
      bcd_d = {adj[DIG_W-2:0], ctl_i.bit_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
    end else begin
      bcd_q <= bcd_d;
    end
  end

  assign bcd_o = bcd_q;

endmodule

[hdl/number_to_ascii_formatter.sv]
// Top level of the number-to-ASCII formatter: request intake, digit
// shift register, character emit FSM. Depends on nta_pkg and nta_dabble.
//
// Channel   Direction  Handshake               Fields
// request   in         start & !busy           value_i, action_i, bit_count_i
// character out        strobe_o (one cycle)    char_code_o, last_o
//
// One request at a time. Decimal: the request is taken in, its magnitude is
// converted to BCD one bit at a time, the BCD digits are loaded, leading zero
// digits are dropped (one is kept), then the characters are emitted. Hex and
// binary skip the conversion: hex drops leading zero digits (keeping one),
// binary drops the bits above its clamped character count, and then the
// characters go out. The '-' of a negative signed value goes out while the
// first magnitude bit is converted. Reset returns the FSM to idle. The
// receiver cannot stall; busy stays high until the last character is out.
module number_to_ascii_formatter
  import nta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  input  logic [1:0]  action_i,
  input  logic [5:0]  bit_count_i,
  output logic        strobe_o,
  output logic [7:0]  char_code_o,
  output logic        last_o
);

  nta_state_e state_q, state_d;
  nta_action_e act_q, act_d;
  logic [DIG_W-1:0] dig_q, dig_d;     // digits, most significant at the top
  logic [5:0] cnt_q, cnt_d;           // digits/bits still in dig_q
  logic [5:0] lim_q, lim_d;           // binary character count
  logic [4:0] step_q, step_d;         // conversion bit counter
  logic       neg_q, neg_d;

  nta_dab_ctl_t dab_ctl;
  logic [DIG_W-1:0] bcd;
  logic [VALUE_W-1:0] mag;
  logic [3:0] top_nib;
  logic       is_bin;

  nta_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dab_ctl),
    .bcd_o  (bcd)
  );

  // magnitude: negate only for a negative signed request
  assign mag = (nta_action_e'(action_i) == ACT_SDEC && value_i[VALUE_W-1])
             ? (~value_i + 32'd1) : value_i;
  assign top_nib = dig_q[DIG_W-1 -: 4];
  assign is_bin  = (act_q == ACT_BIN);
  assign busy    = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    step_d      = step_q;
    neg_d       = neg_q;
    dab_ctl     = '0;
    strobe_o    = 1'b0;
    last_o      = 1'b0;
    char_code_o = ASCII_ZERO;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d  = nta_action_e'(action_i);
          dig_d  = {mag, 8'b0};
          neg_d  = (nta_action_e'(action_i) == ACT_SDEC) && value_i[VALUE_W-1];
          step_d = '0;
          dab_ctl.clr = 1'b1;
          // binary count: 0 -> 1, above 32 -> 32
          if (bit_count_i == 6'd0) begin
            lim_d = 6'd1;
          end else if (bit_count_i > 6'(VALUE_W)) begin
            lim_d = 6'(VALUE_W);
          end else begin
            lim_d = bit_count_i;
          end
          case (nta_action_e'(action_i))
            ACT_BIN: begin
              cnt_d   = 6'(VALUE_W);
              state_d = ST_SKIP;
            end
            ACT_HEX: begin
              cnt_d   = 6'(HEX_DIGITS);
              state_d = ST_SKIP;
            end
            default: begin
              state_d = ST_CONV;
            end
          endcase
        end
      end

      ST_CONV: begin
        // feed one magnitude bit per cycle, MSB first
        dab_ctl.shift  = 1'b1;
        dab_ctl.bit_in = dig_q[DIG_W-1];
        dig_d  = {dig_q[DIG_W-2:0], 1'b0};
        step_d = step_q + 5'd1;
        if (neg_q && step_q == 5'd0) begin
          strobe_o    = 1'b1;
          char_code_o = ASCII_MINUS;
        end
        if (step_q == 5'(CONV_STEPS - 1)) begin
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        dig_d   = bcd;
        cnt_d   = 6'(DEC_DIGITS);
        state_d = ST_SKIP;
      end

      ST_SKIP: begin
        // drop leading zeros (keep one), or align binary to its count
        if (is_bin) begin
          if (cnt_q > lim_q) begin
            dig_d = {dig_q[DIG_W-2:0], 1'b0};
            cnt_d = cnt_q - 6'd1;
          end else begin
            state_d = ST_EMIT;
          end
        end else if (top_nib == 4'd0 && cnt_q > 6'd1) begin
          dig_d = {dig_q[DIG_W-5:0], 4'b0};
          cnt_d = cnt_q - 6'd1;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        strobe_o = 1'b1;
        last_o   = (cnt_q == 6'd1);
        if (is_bin) begin
          char_code_o = ASCII_ZERO + {7'b0, dig_q[DIG_W-1]};
          dig_d       = {dig_q[DIG_W-2:0], 1'b0};
        end else begin
          char_code_o = (top_nib < DEC_BASE) ? ASCII_ZERO + {4'b0, top_nib}
                                             : ASCII_HEX_OFF + {4'b0, top_nib};
          dig_d       = {dig_q[DIG_W-5:0], 4'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload and per-request context
  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    dig_q  <= dig_d;
    cnt_q  <= cnt_d;
    lim_q  <= lim_d;
    step_q <= step_d;
    neg_q  <= neg_d;
  end

endmodule
